>>> hdl/ils_pkg.sv
// Shared constants, codes and types of the indexed list store.
`timescale 1ns / 1ps
`default_nettype none
package ils_pkg;

  localparam int DEPTH   = 256;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int GROUP   = 16;
  localparam int NGROUP  = DEPTH / GROUP;
  localparam int GSEL_W  = $clog2(GROUP);
  localparam int OP_W    = 3;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;
  localparam int CMD_W   = 3;

  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;
  localparam logic [OP_W-1:0] OP_SET_LEN = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ZERO   = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  len;
    logic [WORD_W-1:0] data;
  } ctl_t;

endpackage
`default_nettype wire

>>> hdl/ils_cell.sv
// List cell: holds a word; takes new data, zero or a neighbor's word on a shift.
`timescale 1ns / 1ps
`default_nettype none
module ils_cell (
  input  wire logic                       clk,
  input  wire ils_pkg::ctl_t              ctl,
  input  wire logic [ils_pkg::CNT_W-1:0]  idx,
  input  wire logic [ils_pkg::WORD_W-1:0] left_word,
  input  wire logic [ils_pkg::WORD_W-1:0] right_word,
  output logic      [ils_pkg::WORD_W-1:0] word
);
  import ils_pkg::*;

  logic [WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    case (ctl.cmd)
      CMD_APPEND: begin
        if (idx == ctl.fill) word_next = ctl.data;
      end
      CMD_INSERT: begin
        if (idx > ctl.pos) word_next = left_word;
        else if (idx == ctl.pos) word_next = ctl.data;
      end
      CMD_DELETE: begin
        if (idx >= ctl.pos) word_next = right_word;
      end
      CMD_ZERO: begin
        if (idx >= ctl.fill && idx < ctl.len) word_next = '0;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule
`default_nettype wire

>>> hdl/ils_chain.sv
// Row of list cells with a registered first level of the read selection.
`timescale 1ns / 1ps
`default_nettype none
module ils_chain (
  input  wire logic                                           clk,
  input  wire ils_pkg::ctl_t                                  ctl,
  input  wire logic                                           rd_en,
  input  wire logic [ils_pkg::GSEL_W-1:0]                     rd_lo,
  output logic      [ils_pkg::NGROUP-1:0][ils_pkg::WORD_W-1:0] grp
);
  import ils_pkg::*;

  logic [WORD_W-1:0] cell_word [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end
    ils_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (CNT_W'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i])
    );
  end

  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    logic [WORD_W-1:0] part [GROUP];
    for (genvar k = 0; k < GROUP; k++) begin : g_part
      assign part[k] = cell_word[g*GROUP + k];
    end
    always_ff @(posedge clk) begin
      if (rd_en) grp[g] <= part[rd_lo];
    end
  end

endmodule
`default_nettype wire

>>> hdl/indexed_list_store.sv
// Top level of the indexed list store.
//
// Ordered list of up to 256 signed 32-bit words held in a row of register cells.
// Input channel s_*: one request per item (operation, position, new length, word).
// Output channel m_*: one result per request (status, word read, entry count).
// Each accepted request passes an execute step, in which every cell updates
// at once (append, insert shift, delete shift or zero fill of a whole range)
// while the read path selects within groups of 16 cells, then a read step
// for the final group select into the output register. The sequencer takes no
// new request until the previous result has entered the output register.
// A new request is taken while the previous result still waits in the output
// register; if the receiver stalls, the sequencer holds the finished result
// step until the output register is free, and s_tready stays low meanwhile.
// Reset clears the entry count and all handshake state; cell contents are
// left as they are and become defined only when written.
// A read outside the entry count returns a zero word.
`timescale 1ns / 1ps
`default_nettype none
module indexed_list_store (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [2:0] operation, [10:3] position, [19:11] new_length, [51:20] word_in
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] status, [33:2] word_out, [42:34] count
  output logic [47:0]      m_tdata
);
  import ils_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]              state;
  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        fill_next;
  logic [OP_W-1:0]         req_op;
  logic [POS_W-1:0]        req_pos;
  logic [CNT_W-1:0]        req_len;
  logic [WORD_W-1:0]       req_word;
  logic [STAT_W-1:0]       stat_next;
  logic [STAT_W-1:0]       stat;
  logic                    rd_ok;
  logic [CMD_W-1:0]        cmd_sel;
  logic [CNT_W-1:0]        pos_ext;
  logic [CNT_W-1:0]        depth_c;
  ctl_t                    ctl;
  logic [NGROUP-1:0][WORD_W-1:0] grp;
  logic [WORD_W-1:0]       rd_word;
  logic                    out_load;

  assign pos_ext = CNT_W'(req_pos);
  assign depth_c = CNT_W'(DEPTH);

  always_comb begin
    stat_next = ST_OK;
    cmd_sel   = CMD_NONE;
    fill_next = fill;
    case (req_op)
      OP_APPEND: begin
        if (fill >= depth_c) stat_next = ST_FULL;
        else begin
          cmd_sel   = CMD_APPEND;
          fill_next = fill + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (fill == '0) stat_next = ST_EMPTY;
        else fill_next = fill - 1'b1;
      end
      OP_INSERT: begin
        if (pos_ext >= fill) stat_next = ST_RANGE;
        else if (fill >= depth_c) stat_next = ST_FULL;
        else begin
          cmd_sel   = CMD_INSERT;
          fill_next = fill + 1'b1;
        end
      end
      OP_DELETE: begin
        if (fill == '0) stat_next = ST_EMPTY;
        else if (pos_ext >= fill) stat_next = ST_RANGE;
        else begin
          cmd_sel   = CMD_DELETE;
          fill_next = fill - 1'b1;
        end
      end
      OP_READ: begin
        if (fill == '0) stat_next = ST_EMPTY;
        else if (pos_ext >= fill) stat_next = ST_RANGE;
      end
      OP_SET_LEN: begin
        if (req_len == fill) stat_next = ST_OK;
        else if (req_len > depth_c) stat_next = ST_FULL;
        else begin
          if (req_len > fill) cmd_sel = CMD_ZERO;
          fill_next = req_len;
        end
      end
      OP_CLEAR: begin
        fill_next = '0;
      end
      default: stat_next = ST_RANGE;
    endcase
  end

  always_comb begin
    ctl.cmd  = (state == S_EXEC) ? cmd_sel : CMD_NONE;
    ctl.pos  = pos_ext;
    ctl.fill = fill;
    ctl.len  = req_len;
    ctl.data = req_word;
  end

  ils_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .rd_en (state == S_EXEC),
    .rd_lo (req_pos[GSEL_W-1:0]),
    .grp   (grp)
  );

  assign rd_word  = rd_ok ? grp[req_pos[IDX_W-1:GSEL_W]] : '0;
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_READ) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_op   <= s_tdata[2:0];
      req_pos  <= s_tdata[10:3];
      req_len  <= s_tdata[19:11];
      req_word <= s_tdata[51:20];
    end
    if (state == S_EXEC) begin
      stat  <= stat_next;
      rd_ok <= (req_op == OP_READ) && (stat_next == ST_OK);
    end
    if (out_load) begin
      m_tdata <= {5'd0, fill, rd_word, stat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          fill  <= fill_next;
          state <= S_READ;
        end
        S_READ: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= depth_c)
    else $error("entry count above capacity");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_EXEC)
    else $error("accepted request not executed");
  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_EXEC |=> $stable(fill))
    else $error("entry count changed outside execution");
  a_grow: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && (ctl.cmd == CMD_INSERT || ctl.cmd == CMD_APPEND)
      |=> fill == $past(fill) + 1'b1)
    else $error("entry count did not grow on insert or append");
`endif

endmodule
`default_nettype wire

>>> dv/indexed_list_store_tb.sv
// Self-checking testbench for the indexed list store: directed table, then shaped random requests.
`timescale 1ns / 1ps
module indexed_list_store_tb;
  import ils_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;
  localparam int N_DIRECTED   = 25;
  localparam int N_RANDOM     = 1225;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_FIRST  = 500;
  localparam int QUIET_LAST   = 699;
  localparam int PAUSE_AT     = 900;
  localparam int MODE_SPAN    = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200000;

  typedef enum int {GROW, SHRINK, MIXED, NEAR_FULL} traffic_mode_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [7:0]      pos;
    logic [8:0]      new_len;
    logic [31:0]     word;
  } list_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [31:0]       word_out;
    logic [8:0]        count;
  } list_rsp_t;

  typedef struct packed {
    list_req_t req;
    logic      has_fixed;
    list_rsp_t rsp;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  logic [31:0] list_words [0:DEPTH-1];
  int          list_fill;
  list_rsp_t   pending_results [$];

  int  fail_count;
  int  sent_count;
  int  checked_count;
  int  peak_fill;
  int  cycle_count;
  int  op_hits [0:7];
  int  status_hits [0:3];
  bit  quiet;
  bit  held_off;
  list_rsp_t got;
  list_rsp_t want;

  dir_row_t dir_rows [0:N_DIRECTED-1] = '{
    '{'{OP_READ,      8'd0,   9'd0,   32'h0},        1'b1, '{ST_EMPTY, 32'h0, 9'd0}},
    '{'{OP_REMOVE,    8'd0,   9'd0,   32'h0},        1'b1, '{ST_EMPTY, 32'h0, 9'd0}},
    '{'{OP_DELETE,    8'd0,   9'd0,   32'h0},        1'b1, '{ST_EMPTY, 32'h0, 9'd0}},
    '{'{OP_INSERT,    8'd0,   9'd0,   32'h12345678}, 1'b1, '{ST_RANGE, 32'h0, 9'd0}},
    '{'{OP_UNDEFINED, 8'hff,  9'h1ff, 32'hffffffff}, 1'b1, '{ST_RANGE, 32'h0, 9'd0}},
    '{'{OP_APPEND,    8'd0,   9'd0,   32'h7fffffff}, 1'b1, '{ST_OK,    32'h0, 9'd1}},
    '{'{OP_APPEND,    8'd0,   9'd0,   32'h80000000}, 1'b1, '{ST_OK,    32'h0, 9'd2}},
    '{'{OP_READ,      8'd0,   9'd0,   32'h0},        1'b1, '{ST_OK, 32'h7fffffff, 9'd2}},
    '{'{OP_READ,      8'd1,   9'd0,   32'h0},        1'b1, '{ST_OK, 32'h80000000, 9'd2}},
    '{'{OP_READ,      8'd2,   9'd0,   32'h0},        1'b1, '{ST_RANGE, 32'h0, 9'd2}},
    '{'{OP_INSERT,    8'd1,   9'd0,   32'hffffffff}, 1'b1, '{ST_OK,    32'h0, 9'd3}},
    '{'{OP_READ,      8'd1,   9'd0,   32'h0},        1'b0, '{ST_OK,    32'h0, 9'd0}},
    '{'{OP_READ,      8'd2,   9'd0,   32'h0},        1'b0, '{ST_OK,    32'h0, 9'd0}},
    '{'{OP_DELETE,    8'd0,   9'd0,   32'h0},        1'b1, '{ST_OK,    32'h0, 9'd2}},
    '{'{OP_READ,      8'd0,   9'd0,   32'h0},        1'b0, '{ST_OK,    32'h0, 9'd0}},
    '{'{OP_SET_LEN,   8'd0,   9'd2,   32'h0},        1'b1, '{ST_OK,    32'h0, 9'd2}},
    '{'{OP_SET_LEN,   8'd0,   9'd257, 32'h0},        1'b1, '{ST_FULL,  32'h0, 9'd2}},
    '{'{OP_SET_LEN,   8'd0,   9'h1ff, 32'h0},        1'b1, '{ST_FULL,  32'h0, 9'd2}},
    '{'{OP_SET_LEN,   8'd0,   9'd256, 32'h0},        1'b1, '{ST_OK,    32'h0, 9'd256}},
    '{'{OP_READ,      8'd255, 9'd0,   32'h0},        1'b1, '{ST_OK,    32'h0, 9'd256}},
    '{'{OP_APPEND,    8'd0,   9'd0,   32'h55aa55aa}, 1'b1, '{ST_FULL,  32'h0, 9'd256}},
    '{'{OP_INSERT,    8'd255, 9'd0,   32'haa55aa55}, 1'b1, '{ST_FULL,  32'h0, 9'd256}},
    '{'{OP_DELETE,    8'd255, 9'd0,   32'h0},        1'b1, '{ST_OK,    32'h0, 9'd255}},
    '{'{OP_READ,      8'd255, 9'd0,   32'h0},        1'b1, '{ST_RANGE, 32'h0, 9'd255}},
    '{'{OP_CLEAR,     8'd0,   9'd0,   32'h0},        1'b1, '{ST_OK,    32'h0, 9'd0}}
  };

  indexed_list_store dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic list_rsp_t apply_request(list_req_t r);
    list_rsp_t o;
    int i;
    o.status = ST_OK;
    o.word_out = '0;
    case (r.op)
      OP_APPEND: begin
        if (list_fill >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          list_words[list_fill] = r.word;
          list_fill++;
        end
      end
      OP_REMOVE: begin
        if (list_fill == 0) o.status = ST_EMPTY;
        else list_fill--;
      end
      OP_INSERT: begin
        if (r.pos >= list_fill) begin
          o.status = ST_RANGE;
        end else if (list_fill >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (i = list_fill; i > r.pos; i--) list_words[i] = list_words[i-1];
          list_words[r.pos] = r.word;
          list_fill++;
        end
      end
      OP_DELETE: begin
        if (list_fill == 0) begin
          o.status = ST_EMPTY;
        end else if (r.pos >= list_fill) begin
          o.status = ST_RANGE;
        end else begin
          for (i = r.pos; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
          list_fill--;
        end
      end
      OP_READ: begin
        if (list_fill == 0) o.status = ST_EMPTY;
        else if (r.pos >= list_fill) o.status = ST_RANGE;
        else o.word_out = list_words[r.pos];
      end
      OP_SET_LEN: begin
        if (r.new_len == list_fill) begin
          o.status = ST_OK;
        end else if (r.new_len > DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (i = list_fill; i < r.new_len; i++) list_words[i] = '0;
          list_fill = r.new_len;
        end
      end
      OP_CLEAR: begin
        list_fill = 0;
      end
      default: begin
        o.status = ST_RANGE;
      end
    endcase
    o.count = list_fill[8:0];
    return o;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(traffic_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      GROW: begin
        if (r < 40) return OP_APPEND;
        if (r < 62) return OP_INSERT;
        if (r < 80) return OP_READ;
        if (r < 86) return OP_SET_LEN;
        if (r < 92) return OP_DELETE;
        if (r < 97) return OP_REMOVE;
        return OP_UNDEFINED;
      end
      SHRINK: begin
        if (r < 30) return OP_DELETE;
        if (r < 55) return OP_REMOVE;
        if (r < 75) return OP_READ;
        if (r < 85) return OP_APPEND;
        if (r < 92) return OP_INSERT;
        if (r < 97) return OP_SET_LEN;
        if (r < 99) return OP_CLEAR;
        return OP_UNDEFINED;
      end
      MIXED: begin
        if (r < 18) return OP_APPEND;
        if (r < 32) return OP_INSERT;
        if (r < 46) return OP_DELETE;
        if (r < 58) return OP_REMOVE;
        if (r < 78) return OP_READ;
        if (r < 88) return OP_SET_LEN;
        if (r < 94) return OP_CLEAR;
        return OP_UNDEFINED;
      end
      default: begin
        if (r < 20) return OP_SET_LEN;
        if (r < 45) return OP_APPEND;
        if (r < 65) return OP_INSERT;
        if (r < 85) return OP_READ;
        if (r < 92) return OP_DELETE;
        if (r < 96) return OP_REMOVE;
        return OP_UNDEFINED;
      end
    endcase
  endfunction

  function automatic list_req_t random_request(traffic_mode_t mode);
    list_req_t r;
    int k;
    r.op = pick_op(mode);
    if (list_fill > 0 && $urandom_range(0, 99) < 85) begin
      r.pos = 8'($urandom_range(0, list_fill - 1));
    end else begin
      r.pos = 8'($urandom_range(0, 255));
    end
    k = $urandom_range(0, 9);
    case (k)
      0: r.new_len = 9'($urandom_range(257, 511));
      1: r.new_len = 9'(list_fill);
      2: r.new_len = 9'(DEPTH);
      3: r.new_len = '0;
      default: begin
        if (mode == NEAR_FULL) r.new_len = 9'($urandom_range(240, 256));
        else r.new_len = 9'($urandom_range(0, 256));
      end
    endcase
    k = $urandom_range(0, 7);
    case (k)
      0: r.word = 32'h80000000;
      1: r.word = 32'h7fffffff;
      2: r.word = 32'h0;
      3: r.word = 32'hffffffff;
      default: r.word = $urandom;
    endcase
    return r;
  endfunction

  // enter and leave at a falling edge
  task automatic send_request(list_req_t r, logic has_fixed, list_rsp_t fixed_rsp);
    list_rsp_t predicted;
    while (!quiet && $urandom_range(0, 99) < 23) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, r.word, r.new_len, r.pos, r.op};
    do @(posedge clk); while (!s_tready);
    predicted = apply_request(r);
    if (has_fixed) predicted = fixed_rsp;
    pending_results = {pending_results, predicted};
    op_hits[r.op]++;
    sent_count++;
    if (list_fill > peak_fill) peak_fill = list_fill;
    @(negedge clk);
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    list_fill  = 0;
    fail_count = 0;
    sent_count = 0;
    peak_fill  = 0;
    quiet      = 1'b0;
    foreach (op_hits[i]) op_hits[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(dir_rows[i].req, dir_rows[i].has_fixed, dir_rows[i].rsp);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= QUIET_FIRST && i <= QUIET_LAST);
      if (i == PAUSE_AT) begin
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      send_request(random_request(traffic_mode_t'((i / MODE_SPAN) % 4)), 1'b0, '0);
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests: append %0d remove %0d insert %0d delete %0d read %0d",
             sent_count, op_hits[OP_APPEND], op_hits[OP_REMOVE], op_hits[OP_INSERT],
             op_hits[OP_DELETE], op_hits[OP_READ]);
    $display("  set length %0d clear %0d undefined %0d; %0d results,",
             op_hits[OP_SET_LEN], op_hits[OP_CLEAR], op_hits[OP_UNDEFINED], checked_count);
    $display("  ok/range/empty/full %0d/%0d/%0d/%0d, peak %0d",
             status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_EMPTY],
             status_hits[ST_FULL], peak_fill);
    if (fail_count == 0) begin
      $display("indexed_list_store test passed");
    end else begin
      $display("indexed_list_store test failed");
    end
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    m_tready = 1'b0;
    held_off = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && sent_count >= HOLD_AT) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      m_tready <= quiet || ($urandom_range(0, 99) >= 23);
      @(negedge clk);
    end
  end

  initial begin
    checked_count = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.status   = m_tdata[1:0];
      got.word_out = m_tdata[33:2];
      got.count    = m_tdata[42:34];
      status_hits[got.status]++;
      checked_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d word %h count %0d",
                 $realtime, got.status, got.word_out, got.count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $realtime, want.status, got.status);
          fail_count++;
        end
        if (got.word_out !== want.word_out) begin
          $display("%0t: word_out mismatch expected %h actual %h",
                   $realtime, want.word_out, got.word_out);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count mismatch expected %0d actual %0d",
                   $realtime, want.count, got.count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $realtime, LIMIT_CYCLES);
    $display("indexed_list_store test failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/ils_pkg.sv
hdl/ils_cell.sv
hdl/ils_chain.sv
hdl/indexed_list_store.sv
dv/indexed_list_store_tb.sv
